@@ rtl/tdfe_pkg.sv @@
// Shared types and codes for the transition table state machine engine.
`timescale 1ns / 1ps
`default_nettype none
package tdfe_pkg;

	localparam logic [1:0] FUNC_DEFINE = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_FORCE  = 2'd2;
	localparam logic [1:0] FUNC_APPLY  = 2'd3;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_BAD_STATE     = 3'd1;
	localparam logic [2:0] ST_BAD_SIGNAL    = 3'd2;
	localparam logic [2:0] ST_BAD_TARGET    = 3'd3;
	localparam logic [2:0] ST_DUPLICATE     = 3'd4;
	localparam logic [2:0] ST_NO_TRANSITION = 3'd5;
	localparam logic [2:0] ST_UNDEF_CURRENT = 3'd6;

	localparam logic REG_STATES_IN_USE  = 1'b0;
	localparam logic REG_SIGNALS_IN_USE = 1'b1;

	localparam int STATES_REG_W  = 7;
	localparam int SIGNALS_REG_W = 5;
	localparam int CFG_W         = 7;

	localparam logic [STATES_REG_W-1:0]  STATES_RESET  = 7'd64;
	localparam logic [SIGNALS_REG_W-1:0] SIGNALS_RESET = 5'd16;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] state_num;
		logic [3:0] signal_num;
		logic [5:0] target_state;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] current_state;
		logic [5:0] previous_state;
		logic       moved;
	} rsp_t;

endpackage
`default_nettype wire

@@ rtl/table_driven_fsm_engine_core.sv @@
// Transition table state machine engine: table memory, state flags and item sequencing.
// Flow: a request is registered with its table read, then its status and next state are registered into rsp with done.
// A new request is not taken while busy is high; the table memory read is synchronous.
// Reset: a clearing pass walks every table memory entry with busy high;
// current state 0, no states defined, states_in_use 64, signals_in_use 16.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module table_driven_fsm_engine_core #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SIGNALS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire tdfe_pkg::req_t             req,
	output logic                            done,
	output tdfe_pkg::rsp_t                  rsp,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_idx,
	input  wire logic [tdfe_pkg::CFG_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_STATES * MAX_SIGNALS;
	localparam int IW    = $clog2(DEPTH);
	localparam int SW    = $clog2(MAX_STATES);
	localparam int SB_W  = ($clog2(MAX_STATES + 1) > tdfe_pkg::STATES_REG_W) ?
		$clog2(MAX_STATES + 1) : tdfe_pkg::STATES_REG_W;
	localparam int GB_W  = ($clog2(MAX_SIGNALS + 1) > tdfe_pkg::SIGNALS_REG_W) ?
		$clog2(MAX_SIGNALS + 1) : tdfe_pkg::SIGNALS_REG_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	// table word: valid bit over stored target
	logic [6:0] mem [DEPTH];

	logic [tdfe_pkg::STATES_REG_W-1:0]  states_in_use_q;
	logic [tdfe_pkg::SIGNALS_REG_W-1:0] signals_in_use_q;
	logic [5:0]             present_q;
	logic [MAX_STATES-1:0]  defined_q;
	logic                   clr_q;
	logic [IW-1:0]          clr_idx_q;
	logic                   busy_q;
	tdfe_pkg::req_t         item_s1;
	logic [IW-1:0]          addr_s1;
	logic [6:0]             rd_q;
	logic                   done_q;
	tdfe_pkg::rsp_t         rsp_q;

	logic                   accept;
	logic [5:0]             rd_state;
	logic [IW-1:0]          rd_addr;
	logic                   bad_state;
	logic                   bad_signal;
	logic                   bad_target;
	logic                   bad_current;
	logic                   bad_stored;
	logic [2:0]             status;
	logic [5:0]             next_state;
	logic                   moved;
	logic                   wr_tbl;
	logic                   set_def;

	assign busy   = clr_q | busy_q;
	assign accept = start & ~busy;

	// apply reads the entry of the current state, a transition write that of its source
	assign rd_state = (req.func == tdfe_pkg::FUNC_APPLY) ? present_q : req.state_num;
	assign rd_addr  = IW'(rd_state) * IW'(MAX_SIGNALS) + IW'(req.signal_num);

	assign bad_state = (SB_W'(item_s1.state_num) >= SB_W'(states_in_use_q)) ||
		(SB_W'(item_s1.state_num) >= SB_W'(MAX_STATES));
	assign bad_target = (SB_W'(item_s1.target_state) >= SB_W'(states_in_use_q)) ||
		(SB_W'(item_s1.target_state) >= SB_W'(MAX_STATES));
	assign bad_current = (SB_W'(present_q) >= SB_W'(states_in_use_q)) ||
		(SB_W'(present_q) >= SB_W'(MAX_STATES));
	assign bad_stored = (SB_W'(rd_q[5:0]) >= SB_W'(states_in_use_q)) ||
		(SB_W'(rd_q[5:0]) >= SB_W'(MAX_STATES));
	assign bad_signal = (GB_W'(item_s1.signal_num) >= GB_W'(signals_in_use_q)) ||
		(GB_W'(item_s1.signal_num) >= GB_W'(MAX_SIGNALS));

	always_comb begin
		status     = tdfe_pkg::ST_OK;
		next_state = present_q;
		moved      = 1'b0;
		wr_tbl     = 1'b0;
		set_def    = 1'b0;
		case (item_s1.func)
			tdfe_pkg::FUNC_DEFINE: begin
				if (bad_state) begin
					status = tdfe_pkg::ST_BAD_STATE;
				end else begin
					if (defined_q[SW'(item_s1.state_num)])
						status = tdfe_pkg::ST_DUPLICATE;
					set_def = 1'b1;
				end
			end
			tdfe_pkg::FUNC_WRITE: begin
				if (bad_state) begin
					status = tdfe_pkg::ST_BAD_STATE;
				end else if (bad_signal) begin
					status = tdfe_pkg::ST_BAD_SIGNAL;
				end else if (bad_target) begin
					status = tdfe_pkg::ST_BAD_TARGET;
				end else begin
					if (rd_q[6])
						status = tdfe_pkg::ST_DUPLICATE;
					wr_tbl = 1'b1;
				end
			end
			tdfe_pkg::FUNC_FORCE: begin
				if (bad_state)
					status = tdfe_pkg::ST_BAD_STATE;
				else
					next_state = item_s1.state_num;
			end
			tdfe_pkg::FUNC_APPLY: begin
				if (bad_current || !defined_q[SW'(present_q)]) begin
					status = tdfe_pkg::ST_UNDEF_CURRENT;
				end else if (bad_signal) begin
					status = tdfe_pkg::ST_BAD_SIGNAL;
				end else if (rd_q[6] && !bad_stored) begin
					next_state = rd_q[5:0];
					moved      = 1'b1;
				end else begin
					status = tdfe_pkg::ST_NO_TRANSITION;
				end
			end
			default: begin
				status = tdfe_pkg::ST_OK;
			end
		endcase
	end

	// table memory: one write port shared by the clearing pass and transition writes
	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_idx_q] <= '0;
		else if (busy_q && wr_tbl)
			mem[addr_s1] <= {1'b1, item_s1.target_state};
		if (accept)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_in_use_q  <= tdfe_pkg::STATES_RESET;
			signals_in_use_q <= tdfe_pkg::SIGNALS_RESET;
			present_q        <= '0;
			defined_q        <= '0;
			clr_q            <= 1'b1;
			clr_idx_q        <= '0;
			busy_q           <= 1'b0;
			done_q           <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == tdfe_pkg::REG_STATES_IN_USE)
					states_in_use_q <= cfg_data[tdfe_pkg::STATES_REG_W-1:0];
				else
					signals_in_use_q <= cfg_data[tdfe_pkg::SIGNALS_REG_W-1:0];
			end
			// advance the clearing pass, drop it after the last entry
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_IDX)
					clr_q <= 1'b0;
			end
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				present_q <= next_state;
				if (set_def)
					defined_q[SW'(item_s1.state_num)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
			addr_s1 <= rd_addr;
		end
		if (busy_q) begin
			rsp_q.status         <= status;
			rsp_q.current_state  <= next_state;
			rsp_q.previous_state <= present_q;
			rsp_q.moved          <= moved;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire
